/* rtl/core/arcrot_pkg.sv */
// ============================================================================
// arcrot_pkg
// Shared types and constants for the arcball rotation block.
// ============================================================================
`default_nettype none

package arcrot_pkg;

    // width of the pointer and rotation fields
    localparam int FIELD_W = 16;
    // width of the threshold register
    localparam int THR_W   = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_POST,
        ST_SQRT,
        ST_RND,
        ST_DIV,
        ST_MAPPED
    } state_t;

    // product terms run by the serial multiply-accumulate unit
    typedef enum logic [3:0] {
        T_LEN_X,
        T_LEN_Y,
        T_CX_A,
        T_CX_B,
        T_CY_A,
        T_CY_B,
        T_CZ_A,
        T_CZ_B,
        T_W_A,
        T_W_B,
        T_W_C,
        T_L_A,
        T_L_B,
        T_L_C
    } term_t;

endpackage

`default_nettype wire

/* rtl/core/arcball_rotation.sv */
// ============================================================================
// arcball_rotation
// Maps pointer positions onto the unit sphere and forms the rotation
// quaternion between the click point and the drag point.
// ============================================================================
// A drag runs the bit-serial multiplier (one bit per cycle, 14 products per
// drag), the root loop and, for points off the sphere, the divider loop; a
// click runs the same mapping, stores the start point and raises no m_valid.
// One transaction is in work at a time, the next is taken once the block is
// back in idle. A finished result waits in the output register; the last product
// waits until it is free. Reset (sync, active low) clears state, start, threshold, m_valid.
`default_nettype none

module arcball_rotation #(
    parameter int FRAC_BITS = 14
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire [arcrot_pkg::THR_W-1:0]         cfg_wr_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_mode,
    input  wire signed [arcrot_pkg::FIELD_W-1:0] s_pos_x,
    input  wire signed [arcrot_pkg::FIELD_W-1:0] s_pos_y,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [arcrot_pkg::FIELD_W-1:0] m_rot_x,
    output logic signed [arcrot_pkg::FIELD_W-1:0] m_rot_y,
    output logic signed [arcrot_pkg::FIELD_W-1:0] m_rot_z,
    output logic signed [arcrot_pkg::FIELD_W-1:0] m_rot_w,
    output logic                                m_rot_valid
);

    localparam int FW      = arcrot_pkg::FIELD_W;
    // vector components reach +-1.0, inputs reach +-2.0
    localparam int OP_W    = (FRAC_BITS + 2 > FW) ? FRAC_BITS + 2 : FW;
    // accumulator holds x*x+y*y and sums of three products
    localparam int ACC_W   = (2 * FRAC_BITS + 4 > 34) ? 2 * FRAC_BITS + 4 : 34;
    localparam int SQ_N    = ACC_W / 2;
    localparam int ROOT_W  = SQ_N + 1;
    localparam int REM_W   = ROOT_W + 2;
    localparam int Q_W     = FRAC_BITS + 2;
    localparam int DIV_W   = FRAC_BITS + 18;
    localparam int CNT_MAX = (OP_W > SQ_N) ? OP_W : SQ_N;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [OP_W-1:0]  UNIT   = OP_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] UNIT_A = ACC_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);
    localparam logic [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);

    // control
    arcrot_pkg::state_t state_reg, state_next;
    arcrot_pkg::term_t  t_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               mode_reg;
    logic               outside_reg;
    logic               div_y_reg;
    logic               m_valid_reg;
    logic               fin_go;

    // payload and vectors
    logic signed [FW-1:0]   px_reg, py_reg;
    logic signed [OP_W-1:0] sv_reg [3];
    logic signed [OP_W-1:0] e_reg  [3];
    logic signed [OP_W-1:0] c_reg  [3];
    logic signed [OP_W-1:0] w_reg;
    logic [arcrot_pkg::THR_W-1:0] thr_reg;

    // serial multiply-accumulate
    logic signed [ACC_W-1:0] acc_reg, mcand_reg;
    logic signed [OP_W-1:0]  mplier_reg;
    logic signed [OP_W-1:0]  tm_a, tm_b;
    logic                    tm_neg;
    logic signed [ACC_W-1:0] tm_ext;
    logic signed [OP_W-1:0]  acc_rnd;

    // square root
    logic [ACC_W-1:0]  sq_src_reg;
    logic [REM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh, trial;
    logic [ROOT_W-1:0] r_round;
    logic [ROOT_W-1:0] r_reg;

    // divider
    logic [DIV_W-1:0]       dv_rem_reg, dv_d_reg;
    logic [Q_W-1:0]         dv_q_reg;
    logic [ROOT_W-1:0]      dv_r;
    logic signed [FW-1:0]   dv_p;
    logic [FW:0]            dv_abs;
    logic [DIV_W-1:0]       dv_num;
    logic                   dv_ge;
    logic [Q_W-1:0]         dv_q_next;
    logic [OP_W-1:0]        dv_qs;
    logic signed [OP_W-1:0] dv_res;
    logic                   axis_ok;

    // round-to-nearest shift by FRAC_BITS, ties away from zero, then clamp
    function automatic logic signed [OP_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] m;
        logic [OP_W-1:0]  r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m   = (mag + HALF) >> FRAC_BITS;
        r   = (m > UNIT_A) ? UNIT : m[OP_W-1:0];
        return v[ACC_W-1] ? $signed(-r) : $signed(r);
    endfunction

    // operand table for the product terms
    always_comb begin
        tm_a   = '0;
        tm_b   = '0;
        tm_neg = 1'b0;
        unique case (t_reg)
            arcrot_pkg::T_LEN_X: begin tm_a = OP_W'(px_reg); tm_b = OP_W'(px_reg); end
            arcrot_pkg::T_LEN_Y: begin tm_a = OP_W'(py_reg); tm_b = OP_W'(py_reg); end
            arcrot_pkg::T_CX_A:  begin tm_a = sv_reg[1]; tm_b = e_reg[2]; end
            arcrot_pkg::T_CX_B:  begin tm_a = sv_reg[2]; tm_b = e_reg[1]; tm_neg = 1'b1; end
            arcrot_pkg::T_CY_A:  begin tm_a = sv_reg[2]; tm_b = e_reg[0]; end
            arcrot_pkg::T_CY_B:  begin tm_a = sv_reg[0]; tm_b = e_reg[2]; tm_neg = 1'b1; end
            arcrot_pkg::T_CZ_A:  begin tm_a = sv_reg[0]; tm_b = e_reg[1]; end
            arcrot_pkg::T_CZ_B:  begin tm_a = sv_reg[1]; tm_b = e_reg[0]; tm_neg = 1'b1; end
            arcrot_pkg::T_W_A:   begin tm_a = sv_reg[0]; tm_b = e_reg[0]; end
            arcrot_pkg::T_W_B:   begin tm_a = sv_reg[1]; tm_b = e_reg[1]; end
            arcrot_pkg::T_W_C:   begin tm_a = sv_reg[2]; tm_b = e_reg[2]; end
            arcrot_pkg::T_L_A:   begin tm_a = c_reg[0]; tm_b = c_reg[0]; end
            arcrot_pkg::T_L_B:   begin tm_a = c_reg[1]; tm_b = c_reg[1]; end
            arcrot_pkg::T_L_C:   begin tm_a = c_reg[2]; tm_b = c_reg[2]; end
            default: begin tm_a = '0; tm_b = '0; end
        endcase
    end

    assign tm_ext  = ACC_W'(tm_a);
    assign acc_rnd = rnd_sat(acc_reg);
    assign axis_ok = acc_reg > ACC_W'(thr_reg);

    // one root digit per cycle
    assign rem_sh  = {sq_rem_reg[REM_W-3:0], sq_src_reg[ACC_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign r_round = root_reg + ROOT_W'(sq_rem_reg > REM_W'(root_reg));

    // divider operand: x when leaving the root, y on the second pass
    assign dv_r   = (state_reg == arcrot_pkg::ST_RND) ? r_round : r_reg;
    assign dv_p   = (state_reg == arcrot_pkg::ST_RND) ? px_reg : py_reg;
    assign dv_abs = dv_p[FW-1] ? ((FW+1)'(0) - {dv_p[FW-1], dv_p}) : {1'b0, dv_p};
    assign dv_num = (DIV_W'(dv_abs) << FRAC_BITS) + DIV_W'(dv_r >> 1);

    assign dv_ge     = dv_rem_reg >= dv_d_reg;
    assign dv_q_next = {dv_q_reg[Q_W-2:0], dv_ge};
    assign dv_qs     = (OP_W'(dv_q_next) > UNIT) ? UNIT : OP_W'(dv_q_next);
    // quotient sign follows the coordinate being divided
    assign dv_res    = (div_y_reg ? py_reg[FW-1] : px_reg[FW-1]) ? $signed(-dv_qs)
                                                                 : $signed(dv_qs);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            arcrot_pkg::ST_IDLE:
                if (s_valid) state_next = arcrot_pkg::ST_LOAD;
            arcrot_pkg::ST_LOAD:
                state_next = arcrot_pkg::ST_MAC;
            arcrot_pkg::ST_MAC:
                if (cnt_reg == CNT_W'(OP_W - 1)) state_next = arcrot_pkg::ST_POST;
            arcrot_pkg::ST_POST: begin
                if (t_reg == arcrot_pkg::T_LEN_Y) begin
                    state_next = arcrot_pkg::ST_SQRT;
                end else if (t_reg == arcrot_pkg::T_L_C) begin
                    if (fin_go) state_next = arcrot_pkg::ST_IDLE;
                end else begin
                    state_next = arcrot_pkg::ST_LOAD;
                end
            end
            arcrot_pkg::ST_SQRT:
                if (cnt_reg == CNT_W'(SQ_N - 1)) state_next = arcrot_pkg::ST_RND;
            arcrot_pkg::ST_RND:
                state_next = outside_reg ? arcrot_pkg::ST_DIV : arcrot_pkg::ST_MAPPED;
            arcrot_pkg::ST_DIV:
                if (cnt_reg == CNT_W'(Q_W - 1) && div_y_reg) state_next = arcrot_pkg::ST_MAPPED;
            arcrot_pkg::ST_MAPPED:
                state_next = mode_reg ? arcrot_pkg::ST_LOAD : arcrot_pkg::ST_IDLE;
            default:
                state_next = arcrot_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready = 1'b0;
        fin_go  = 1'b0;
        unique case (state_reg)
            arcrot_pkg::ST_IDLE: s_ready = 1'b1;
            // last product done: hand off once the output register is free
            arcrot_pkg::ST_POST: fin_go = (t_reg == arcrot_pkg::T_L_C) &&
                                          (!m_valid_reg || m_ready);
            default: begin
                s_ready = 1'b0;
                fin_go  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= arcrot_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            thr_reg     <= '0;
            sv_reg[0]   <= '0;
            sv_reg[1]   <= '0;
            sv_reg[2]   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) thr_reg <= cfg_wr_data;
            if (m_valid_reg && m_ready && !fin_go) m_valid_reg <= 1'b0;

            unique case (state_reg)
                arcrot_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_mode;
                        px_reg   <= s_pos_x;
                        py_reg   <= s_pos_y;
                        t_reg    <= arcrot_pkg::T_LEN_X;
                        acc_reg  <= '0;
                    end
                end
                arcrot_pkg::ST_LOAD: begin
                    mcand_reg  <= tm_neg ? -tm_ext : tm_ext;
                    mplier_reg <= tm_b;
                    cnt_reg    <= '0;
                end
                arcrot_pkg::ST_MAC: begin
                    // sign bit of the multiplier carries negative weight
                    if (mplier_reg[0]) begin
                        if (cnt_reg == CNT_W'(OP_W - 1)) acc_reg <= acc_reg - mcand_reg;
                        else                             acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >>> 1;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                end
                arcrot_pkg::ST_POST: begin
                    priority case (t_reg)
                        arcrot_pkg::T_LEN_Y: begin
                            outside_reg <= acc_reg > $signed(ONE_SQ);
                            sq_src_reg  <= (acc_reg > $signed(ONE_SQ)) ? ACC_W'(acc_reg)
                                                                     : ONE_SQ - ACC_W'(acc_reg);
                            sq_rem_reg  <= '0;
                            root_reg    <= '0;
                            cnt_reg     <= '0;
                        end
                        arcrot_pkg::T_CX_B: begin
                            c_reg[0] <= acc_rnd;
                            acc_reg  <= '0;
                        end
                        arcrot_pkg::T_CY_B: begin
                            c_reg[1] <= acc_rnd;
                            acc_reg  <= '0;
                        end
                        arcrot_pkg::T_CZ_B: begin
                            c_reg[2] <= acc_rnd;
                            acc_reg  <= '0;
                        end
                        arcrot_pkg::T_W_C: begin
                            w_reg   <= acc_rnd;
                            acc_reg <= '0;
                        end
                        arcrot_pkg::T_L_C: begin
                            if (fin_go) begin
                                m_valid_reg <= 1'b1;
                                m_rot_valid <= axis_ok;
                                m_rot_x     <= axis_ok ? c_reg[0][FW-1:0] : '0;
                                m_rot_y     <= axis_ok ? c_reg[1][FW-1:0] : '0;
                                m_rot_z     <= axis_ok ? c_reg[2][FW-1:0] : '0;
                                m_rot_w     <= axis_ok ? w_reg[FW-1:0] : '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (t_reg != arcrot_pkg::T_LEN_Y && t_reg != arcrot_pkg::T_L_C)
                        t_reg <= arcrot_pkg::term_t'(t_reg + 4'd1);
                end
                arcrot_pkg::ST_SQRT: begin
                    if (rem_sh >= trial) begin
                        sq_rem_reg <= rem_sh - trial;
                        root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
                    end else begin
                        sq_rem_reg <= rem_sh;
                        root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    sq_src_reg <= sq_src_reg << 2;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                end
                arcrot_pkg::ST_RND: begin
                    r_reg <= r_round;
                    if (outside_reg) begin
                        div_y_reg  <= 1'b0;
                        dv_rem_reg <= dv_num;
                        dv_d_reg   <= DIV_W'(dv_r) << (Q_W - 1);
                        dv_q_reg   <= '0;
                        cnt_reg    <= '0;
                    end else begin
                        e_reg[0] <= OP_W'(px_reg);
                        e_reg[1] <= OP_W'(py_reg);
                        e_reg[2] <= OP_W'(r_round);
                    end
                end
                arcrot_pkg::ST_DIV: begin
                    if (dv_ge) dv_rem_reg <= dv_rem_reg - dv_d_reg;
                    dv_d_reg <= dv_d_reg >> 1;
                    dv_q_reg <= dv_q_next;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(Q_W - 1)) begin
                        if (div_y_reg) begin
                            e_reg[1] <= dv_res;
                            e_reg[2] <= '0;
                        end else begin
                            // x done: restart for y
                            e_reg[0]   <= dv_res;
                            div_y_reg  <= 1'b1;
                            dv_rem_reg <= dv_num;
                            dv_d_reg   <= DIV_W'(dv_r) << (Q_W - 1);
                            dv_q_reg   <= '0;
                            cnt_reg    <= '0;
                        end
                    end
                end
                arcrot_pkg::ST_MAPPED: begin
                    if (mode_reg) begin
                        t_reg   <= arcrot_pkg::T_CX_A;
                        acc_reg <= '0;
                    end else begin
                        sv_reg[0] <= e_reg[0];
                        sv_reg[1] <= e_reg[1];
                        sv_reg[2] <= e_reg[2];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
